// ===== rtl/act_pkg.sv =====
package act_pkg;

  localparam int unsigned IpW   = 32;
  localparam int unsigned MacW  = 48;
  localparam int unsigned SlotW = 3;

  // Answer given on a lookup miss: the broadcast address.
  localparam logic [MacW-1:0] BroadcastMac = 48'hFFFF_FFFF_FFFF;

  typedef enum logic {
    OpLookup = 1'b0,
    OpLearn  = 1'b1
  } op_e;

endpackage

// ===== rtl/arp_cache_table.sv =====
// The input register takes each accepted word; its result word is then
// registered in the result register and valid on the outputs.
// Throughput: one word per cycle unless the output stalls; a lookup or learn
// may follow the previous one directly and sees the table as that one left it.
// Reset clears every valid bit at once, so the table starts empty and no
// clearing pass is needed; slot contents are undefined until written.
module arp_cache_table #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [act_pkg::IpW-1:0]   ip_addr_i,
  input  logic [act_pkg::MacW-1:0]  mac_addr_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [act_pkg::MacW-1:0]  mac_out_o,
  output logic                      request_needed_o,
  output logic [act_pkg::SlotW-1:0] slot_index_o
);
  import act_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Input register: holds the word being worked on against the table.
  logic            s1_valid_q;
  op_e             s1_op_q;
  logic [IpW-1:0]  s1_ip_q;
  logic [MacW-1:0] s1_mac_q;

  // Result register: the answer waits here until the consumer takes it.
  logic             out_valid_q;
  logic             hit_q,     hit_d;
  logic [MacW-1:0]  mac_q,     mac_d;
  logic             req_q,     req_d;
  logic [SlotW-1:0] slot_q,    slot_d;

  logic advance;
  logic s1_fire;

  // Table view and match results.
  logic [IpW-1:0]     entry_ip    [ENTRIES];
  logic [MacW-1:0]    entry_mac   [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic               match_hit;
  logic [IdxW-1:0]    match_idx;
  logic [MacW-1:0]    match_mac;
  logic [IdxW-1:0]    free_idx;

  logic            store_we;
  logic [IdxW-1:0] store_idx;

  // Slot numbers are reported in a fixed three-bit field, so the index is
  // zero-extended and then cut to that width.
  logic [IdxW+SlotW-1:0] match_ext;
  logic [IdxW+SlotW-1:0] store_ext;

  // The result register moves on whenever it is empty or being drained, and
  // the input register refills in the same cycle it is emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q  <= op_e'(opcode_i);
      s1_ip_q  <= ip_addr_i;
      s1_mac_q <= mac_addr_i;
    end
  end

  act_store #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .we_i          (store_we),
    .wr_idx_i      (store_idx),
    .wr_ip_i       (s1_ip_q),
    .wr_mac_i      (s1_mac_q),
    .entry_ip_o    (entry_ip),
    .entry_mac_o   (entry_mac),
    .entry_valid_o (entry_valid)
  );

  act_match #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW)
  ) u_match (
    .key_ip_i      (s1_ip_q),
    .entry_ip_i    (entry_ip),
    .entry_mac_i   (entry_mac),
    .entry_valid_i (entry_valid),
    .hit_o         (match_hit),
    .match_idx_o   (match_idx),
    .match_mac_o   (match_mac),
    .free_idx_o    (free_idx)
  );

  // A learn updates the matching slot in place, otherwise it claims the
  // lowest free slot, falling back to slot 0 when the table is full. The
  // table is written in the same cycle the result is registered, so the
  // next word already sees the change.
  assign store_we  = s1_fire && (s1_op_q == OpLearn);
  assign store_idx = match_hit ? match_idx : free_idx;

  assign match_ext = {{SlotW{1'b0}}, match_idx};
  assign store_ext = {{SlotW{1'b0}}, store_idx};

  always_comb begin
    hit_d  = match_hit;
    mac_d  = '0;
    req_d  = 1'b0;
    slot_d = store_ext[SlotW-1:0];
    case (s1_op_q)
      OpLookup: begin
        if (match_hit) begin
          mac_d  = match_mac;
          slot_d = match_ext[SlotW-1:0];
        end else begin
          mac_d  = BroadcastMac;
          req_d  = 1'b1;
          slot_d = '0;
        end
      end
      OpLearn: begin
        mac_d  = '0;
        slot_d = store_ext[SlotW-1:0];
      end
      default: begin
        mac_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      hit_q  <= hit_d;
      mac_q  <= mac_d;
      req_q  <= req_d;
      slot_q <= slot_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign mac_out_o        = mac_q;
  assign request_needed_o = req_q;
  assign slot_index_o     = slot_q;

endmodule

// ===== rtl/act_store.sv =====
module act_store #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [IdxW-1:0]          wr_idx_i,
  input  logic [act_pkg::IpW-1:0]  wr_ip_i,
  input  logic [act_pkg::MacW-1:0] wr_mac_i,
  output logic [act_pkg::IpW-1:0]  entry_ip_o    [ENTRIES],
  output logic [act_pkg::MacW-1:0] entry_mac_o   [ENTRIES],
  output logic [ENTRIES-1:0]       entry_valid_o
);
  import act_pkg::*;

  logic [IpW-1:0]     ip_q    [ENTRIES];
  logic [MacW-1:0]    mac_q   [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  // Address and MAC storage needs no reset: each slot is read only once valid.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (we_i && (wr_idx_i == IdxW'(i))) begin
        ip_q[i]  <= wr_ip_i;
        mac_q[i] <= wr_mac_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (we_i && (wr_idx_i == IdxW'(i))) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  assign entry_ip_o    = ip_q;
  assign entry_mac_o   = mac_q;
  assign entry_valid_o = valid_q;

endmodule

// ===== rtl/act_match.sv =====
module act_match #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [act_pkg::IpW-1:0]  key_ip_i,
  input  logic [act_pkg::IpW-1:0]  entry_ip_i    [ENTRIES],
  input  logic [act_pkg::MacW-1:0] entry_mac_i   [ENTRIES],
  input  logic [ENTRIES-1:0]       entry_valid_i,
  output logic                     hit_o,
  output logic [IdxW-1:0]          match_idx_o,
  output logic [act_pkg::MacW-1:0] match_mac_o,
  output logic [IdxW-1:0]          free_idx_o
);
  import act_pkg::*;

  logic [ENTRIES-1:0] hit_vec;

  // Every slot is compared in parallel; the lowest numbered match wins.
  always_comb begin
    hit_vec     = '0;
    match_idx_o = '0;
    free_idx_o  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid_i[i] && (entry_ip_i[i] == key_ip_i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        match_idx_o = IdxW'(i);
      end
      if (!entry_valid_i[i]) begin
        free_idx_o = IdxW'(i);
      end
    end
  end

  // When the cache is full the free index stays at slot 0.
  assign hit_o       = |hit_vec;
  assign match_mac_o = entry_mac_i[match_idx_o];

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import act_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The cache under test has eight slots; the local copy below mirrors that.
  localparam int unsigned Slots       = 8;
  localparam int unsigned RandomWords = 600;
  localparam int unsigned PoolSize    = 12;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned MaxReports  = 10;

  // One answer word as the block presents it on its output ports.
  typedef struct packed {
    logic             hit;
    logic [MacW-1:0]  mac;
    logic             request;
    logic [SlotW-1:0] slot;
  } arp_answer_t;

  // One row of the directed stimulus. Where "fixed" is set, the answer is
  // typed into the row; otherwise it comes from the local cache model.
  typedef struct {
    op_e            op;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
    bit             fixed;
    arp_answer_t    answer;
  } stim_row_t;

  localparam arp_answer_t Predicted = '0;
  localparam logic [IpW-1:0] IpAllOnes = '1;
  localparam logic [MacW-1:0] MacAllOnes = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                opcode_i;
  logic [IpW-1:0]      ip_addr_i;
  logic [MacW-1:0]     mac_addr_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                hit_o;
  logic [MacW-1:0]     mac_out_o;
  logic                request_needed_o;
  logic [SlotW-1:0]    slot_index_o;

  // Local copy of the cache contents, updated as each input word is taken.
  logic [IpW-1:0]      cache_ip    [Slots];
  logic [MacW-1:0]     cache_mac   [Slots];
  bit                  cache_valid [Slots];

  arp_answer_t         pending_answers[$];
  logic [IpW-1:0]      ip_pool[PoolSize];
  stim_row_t           directed_rows[22];

  int unsigned         mismatches;
  int unsigned         answers_seen;
  int unsigned         quiet_cycles;
  bit                  calm_phase;

  arp_cache_table #(
    .ENTRIES(Slots)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .ip_addr_i        (ip_addr_i),
    .mac_addr_i       (mac_addr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .mac_out_o        (mac_out_o),
    .request_needed_o (request_needed_o),
    .slot_index_o     (slot_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Resolves one word against the local cache and updates it, exactly as the
  // block should: the lowest valid match wins, a learn without a match takes
  // the lowest free slot, and a full cache gives up slot 0.
  function automatic arp_answer_t resolve_arp_word(op_e op, logic [IpW-1:0] ip,
                                                   logic [MacW-1:0] mac);
    arp_answer_t answer;
    int          match;
    int          target;
    answer = '0;
    match  = -1;
    target = 0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (cache_valid[i] && cache_ip[i] == ip) begin
        match = i;
      end
    end
    if (op == OpLookup) begin
      if (match >= 0) begin
        answer.hit  = 1'b1;
        answer.mac  = cache_mac[match];
        answer.slot = SlotW'(match);
      end else begin
        answer.mac     = BroadcastMac;
        answer.request = 1'b1;
      end
    end else if (match >= 0) begin
      // A known address only has its MAC refreshed; the slot stays put.
      cache_mac[match] = mac;
      answer.hit       = 1'b1;
      answer.slot      = SlotW'(match);
    end else begin
      for (int i = Slots - 1; i >= 0; i--) begin
        if (!cache_valid[i]) begin
          target = i;
        end
      end
      cache_ip[target]    = ip;
      cache_mac[target]   = mac;
      cache_valid[target] = 1'b1;
      answer.slot         = SlotW'(target);
    end
    return answer;
  endfunction

  // Offers one input word, holding it steady until the block takes it, and
  // files the answer expected for it at the edge of acceptance.
  task automatic offer_arp_word(input op_e op, input logic [IpW-1:0] ip,
                                input logic [MacW-1:0] mac, input bit fixed,
                                input arp_answer_t answer);
    arp_answer_t predicted;
    if (!calm_phase) begin
      while ($urandom_range(99) < 35) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    ip_addr_i  <= ip;
    mac_addr_i <= mac;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = resolve_arp_word(op, ip, mac);
    pending_answers.push_back(fixed ? answer : predicted);
  endtask

  // Picks an address for a random word: mostly one already held in the
  // cache or one from the working set, so that hits, refreshes and slot 0
  // evictions are common; the rest is arbitrary noise.
  function automatic logic [IpW-1:0] pick_address();
    int unsigned held[$];
    int unsigned roll;
    roll = $urandom_range(99);
    for (int i = 0; i < Slots; i++) begin
      if (cache_valid[i]) begin
        held.push_back(i);
      end
    end
    if (roll < 40 && held.size() != 0) begin
      return cache_ip[held[$urandom_range(held.size() - 1)]];
    end else if (roll < 80) begin
      return ip_pool[$urandom_range(PoolSize - 1)];
    end
    return $urandom;
  endfunction

  // Receiver: random back-pressure, none during the calm phase except one long
  // hold-off, which takes precedence, once a few hundred answers have come out,
  // so that the pipeline fills and the input side has to stall.
  initial begin
    int unsigned hold_left;
    bit          held_once;
    hold_left   = 0;
    held_once   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_once && answers_seen >= 300) begin
        held_once = 1'b1;
        hold_left = 64;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm_phase) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Checker: every answer word taken must match the oldest pending answer.
  always @(posedge clk_i) begin
    arp_answer_t got;
    arp_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{hit_o, mac_out_o, request_needed_o, slot_index_o};
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected answer word: hit %0b mac %h request %0b slot %0d",
                   got.hit, got.mac, got.request, got.slot);
        end
      end else begin
        want = pending_answers.pop_front();
        if (got.hit !== want.hit || got.mac !== want.mac ||
            got.request !== want.request || got.slot !== want.slot) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("answer mismatch: expected hit %0b mac %h request %0b slot %0d",
                     want.hit, want.mac, want.request, want.slot);
            $display("                 got      hit %0b mac %h request %0b slot %0d",
                     got.hit, got.mac, got.request, got.slot);
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which neither side moves a word means
  // the block has locked up.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] mac_draw;
    op_e         op;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = 1'b0;
    ip_addr_i    = '0;
    mac_addr_i   = '0;
    mismatches   = 0;
    answers_seen = 0;
    quiet_cycles = 0;
    calm_phase   = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
      cache_valid[i] = 1'b0;
    end

    // The first rows are answered on sight: an empty cache misses with the
    // broadcast MAC, the first learns land in slots 0 and 1, and a second
    // learn of a known address refreshes it in place. Later rows fill the
    // cache, force the slot 0 eviction when it is full and look at the
    // aftermath; those are left to the model.
    directed_rows = '{
      '{OpLookup, '0,           MacAllOnes,       1'b1, '{1'b0, BroadcastMac, 1'b1, 3'd0}},
      '{OpLookup, IpAllOnes,    '0,               1'b1, '{1'b0, BroadcastMac, 1'b1, 3'd0}},
      '{OpLearn,  '0,           '0,               1'b1, '{1'b0, 48'h0, 1'b0, 3'd0}},
      '{OpLearn,  IpAllOnes,    MacAllOnes,       1'b1, '{1'b0, 48'h0, 1'b0, 3'd1}},
      '{OpLookup, '0,           MacAllOnes,       1'b1, '{1'b1, 48'h0, 1'b0, 3'd0}},
      '{OpLookup, IpAllOnes,    '0,               1'b1, '{1'b1, MacAllOnes, 1'b0, 3'd1}},
      '{OpLearn,  '0,           48'h0123456789AB, 1'b1, '{1'b1, 48'h0, 1'b0, 3'd0}},
      '{OpLookup, '0,           MacAllOnes,       1'b1, '{1'b1, 48'h0123456789AB, 1'b0, 3'd0}},
      '{OpLearn,  32'h0A000002, 48'h020000000002, 1'b0, Predicted},
      '{OpLearn,  32'h0A000003, 48'h020000000003, 1'b0, Predicted},
      '{OpLearn,  32'h0A000004, 48'h020000000004, 1'b0, Predicted},
      '{OpLearn,  32'h0A000005, 48'h020000000005, 1'b0, Predicted},
      '{OpLearn,  32'h0A000006, 48'h020000000006, 1'b0, Predicted},
      '{OpLearn,  32'h0A000007, 48'h020000000007, 1'b0, Predicted},
      '{OpLookup, 32'h0A000007, '0,               1'b0, Predicted},
      '{OpLearn,  32'hC0A80001, 48'hFEDCBA987654, 1'b0, Predicted},
      '{OpLookup, '0,           '0,               1'b0, Predicted},
      '{OpLookup, 32'hC0A80001, 48'h555555555555, 1'b0, Predicted},
      '{OpLearn,  32'hAAAAAAAA, 48'h555555555555, 1'b0, Predicted},
      '{OpLookup, 32'h55555555, 48'hAAAAAAAAAAAA, 1'b0, Predicted},
      '{OpLearn,  32'h0A000004, 48'hAAAAAAAAAAAA, 1'b0, Predicted},
      '{OpLookup, 32'hAAAAAAAA, '0,               1'b0, Predicted}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_arp_word(directed_rows[i].op, directed_rows[i].ip, directed_rows[i].mac,
                     directed_rows[i].fixed, directed_rows[i].answer);
    end

    // Random words. The working set of addresses is larger than the cache,
    // so it overflows and evicts slot 0, and it is renewed now and then so
    // that fresh addresses keep arriving. The middle stretch runs with no random
    // idling on either side.
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 120 == 0) begin
        foreach (ip_pool[k]) begin
          ip_pool[k] = $urandom;
        end
        ip_pool[0] = (n % 240 == 0) ? '0 : IpAllOnes;
      end
      calm_phase = (n >= 250 && n < 420);
      op         = ($urandom_range(1) != 0) ? OpLearn : OpLookup;
      mac_draw   = {$urandom, $urandom};
      offer_arp_word(op, pick_address(), mac_draw[MacW-1:0], 1'b0, Predicted);
    end
    in_valid_i <= 1'b0;
    calm_phase  = 1'b0;

    while (pending_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/act_pkg.sv
rtl/act_store.sv
rtl/act_match.sv
rtl/arp_cache_table.sv
verif/testbench.sv
